// ----- hdl/sfr_pkg.sv -----
// Shared types and constants for the serial frame receiver.
// No dependencies; every other file in hdl/ except sfr_if.sv imports this package.
package sfr_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] MIN_LENGTH  = 8'd7;

  // Configuration port geometry: three 8-bit registers at byte addresses 0, 4, 8.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_ANSWER_CODE = 2'd0,
    REG_REPORT_CODE = 2'd1,
    REG_ERROR_CODE  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_HUNT_FIRST  = 2'd0,
    PH_HUNT_SECOND = 2'd1,
    PH_LENGTH      = 2'd2,
    PH_BODY        = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_SUM   = 2'd1,
    ST_SHORT_LEN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_ANSWER = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] answer_code;
    logic [7:0] report_code;
    logic [7:0] error_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [1:0]  frame_kind;
    logic [7:0]  cmd_byte;
    logic [7:0]  func_code;
    logic [31:0] payload;
    logic [7:0]  frame_length;
  } result_t;

endpackage

// ----- hdl/sfr_if.sv -----
// Valid/ready channel interfaces for received bytes and parsed frames.
// No dependencies.
interface sfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_frame_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [1:0]  frame_kind;
  logic [7:0]  cmd_byte;
  logic [7:0]  func_code;
  logic [31:0] payload;
  logic [7:0]  frame_length;

  modport source (output valid, output frame_status, output frame_kind, output cmd_byte,
                  output func_code, output payload, output frame_length, input ready);
  modport sink (input valid, input frame_status, input frame_kind, input cmd_byte,
                input func_code, input payload, input frame_length, output ready);
endinterface

// ----- hdl/sfr_cfg_regs.sv -----
// APB-style register bank holding the three cmd classification codes.
// Depends on sfr_pkg.
module sfr_cfg_regs
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  reg_index_t index;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign index  = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.answer_code <= 8'd2;
      cfg.report_code <= 8'd3;
      cfg.error_code  <= 8'd4;
    end else if (wr_en) begin
      case (index)
        REG_ANSWER_CODE: cfg.answer_code <= pwdata[7:0];
        REG_REPORT_CODE: cfg.report_code <= pwdata[7:0];
        REG_ERROR_CODE:  cfg.error_code  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_ANSWER_CODE: prdata = {{(DATA_W-8){1'b0}}, cfg.answer_code};
      REG_REPORT_CODE: prdata = {{(DATA_W-8){1'b0}}, cfg.report_code};
      REG_ERROR_CODE:  prdata = {{(DATA_W-8){1'b0}}, cfg.error_code};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- hdl/sfr_parser.sv -----
// Frame parser: header hunt, length capture, field capture and checksum check.
// Depends on sfr_pkg. Produces one result per completed frame, combinationally on accept.
module sfr_parser
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       emit,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  length_value, length_value_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  cmd_hold, cmd_hold_next;
  logic [7:0]  func_hold, func_hold_next;
  logic [31:0] payload_hold, payload_hold_next;

  logic [7:0]  count_inc;
  logic [7:0]  res_cmd;
  status_t     res_status;
  kind_t       res_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT_FIRST;
      byte_count   <= '0;
      length_value <= '0;
      running_sum  <= '0;
      cmd_hold     <= '0;
      func_hold    <= '0;
      payload_hold <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      length_value <= length_value_next;
      running_sum  <= running_sum_next;
      cmd_hold     <= cmd_hold_next;
      func_hold    <= func_hold_next;
      payload_hold <= payload_hold_next;
    end
  end

  assign count_inc = byte_count + 8'd1;

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    length_value_next = length_value;
    running_sum_next  = running_sum;
    cmd_hold_next     = cmd_hold;
    func_hold_next    = func_hold;
    payload_hold_next = payload_hold;
    emit              = 1'b0;
    res_status        = ST_GOOD;
    case (phase)
      PH_HUNT_FIRST: begin
        if (rx_byte == HEADER_BYTE) phase_next = PH_HUNT_SECOND;
      end
      PH_HUNT_SECOND: begin
        phase_next = (rx_byte == HEADER_BYTE) ? PH_LENGTH : PH_HUNT_FIRST;
      end
      PH_LENGTH: begin
        length_value_next = rx_byte;
        running_sum_next  = rx_byte;
        byte_count_next   = '0;
        cmd_hold_next     = '0;
        func_hold_next    = '0;
        payload_hold_next = '0;
        if (rx_byte == 8'd0) begin
          // empty frame completes on the length byte
          emit       = 1'b1;
          res_status = ST_SHORT_LEN;
          phase_next = PH_HUNT_FIRST;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        byte_count_next = count_inc;
        if (count_inc >= length_value) begin
          // last body byte is the checksum; never captured
          emit       = 1'b1;
          phase_next = PH_HUNT_FIRST;
          if (length_value < MIN_LENGTH)    res_status = ST_SHORT_LEN;
          else if (rx_byte != running_sum)  res_status = ST_BAD_SUM;
          else                              res_status = ST_GOOD;
        end else begin
          running_sum_next = running_sum + rx_byte;
          case (count_inc)
            8'd1: cmd_hold_next = rx_byte;
            8'd2: func_hold_next = rx_byte;
            8'd3: payload_hold_next[7:0]   = rx_byte;
            8'd4: payload_hold_next[15:8]  = rx_byte;
            8'd5: payload_hold_next[23:16] = rx_byte;
            8'd6: payload_hold_next[31:24] = rx_byte;
            default: ;
          endcase
        end
      end
      default: phase_next = PH_HUNT_FIRST;
    endcase
  end

  // captured fields are all zero when the frame ends on the length byte
  assign res_cmd = (phase == PH_LENGTH) ? 8'd0 : cmd_hold;

  always_comb begin
    if (res_cmd == cfg.answer_code)      res_kind = KIND_ANSWER;
    else if (res_cmd == cfg.report_code) res_kind = KIND_REPORT;
    else if (res_cmd == cfg.error_code)  res_kind = KIND_ERROR;
    else                                 res_kind = KIND_OTHER;
  end

  always_comb begin
    result.frame_status = res_status;
    result.frame_kind   = res_kind;
    result.cmd_byte     = res_cmd;
    result.func_code    = (phase == PH_LENGTH) ? 8'd0 : func_hold;
    result.payload      = (phase == PH_LENGTH) ? 32'd0 : payload_hold;
    result.frame_length = (phase == PH_LENGTH) ? rx_byte : length_value;
  end

endmodule

// ----- hdl/sfr_out_queue.sv -----
// Two-entry result register with skid slot between parser and output channel.
// Depends on sfr_pkg.
module sfr_out_queue
  import sfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid & out_ready;
  // every transfer in yields at most one result, so one free slot is enough
  assign has_room  = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/serial_frame_receiver.sv -----
// Top level of the serial frame receiver: byte channel in, frame channel out, APB config.
// Depends on sfr_pkg, sfr_if, sfr_cfg_regs, sfr_parser, sfr_out_queue.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+------------------------------------------
//   rx       | in  | valid/ready           | rx_byte[7:0]
//   frame    | out | valid/ready           | status, kind, cmd, func, payload, length
//   apb      | in  | psel/penable/pready   | 3 x 8-bit codes at 0x0, 0x4, 0x8
//
// One byte per cycle while rx.ready is high: the parser state updates in the
// accepting cycle and a completed frame lands in the output queue on the same
// edge, visible next cycle. The output queue holds two frames; rx.ready drops
// only when both are full. Reset (rst, synchronous) returns to header hunt,
// empties the queue and loads the codes with 2, 3 and 4.
module serial_frame_receiver
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sfr_byte_if.sink          rx,
  sfr_frame_if.source       frame,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  logic    accept;
  logic    emit;
  logic    has_room;
  result_t result;
  result_t out_data;

  assign rx.ready = has_room;
  assign accept   = rx.valid & has_room;

  sfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg),
    .emit    (emit),
    .result  (result)
  );

  sfr_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept & emit),
    .push_data (result),
    .has_room  (has_room),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_data  (out_data)
  );

  assign frame.frame_status = out_data.frame_status;
  assign frame.frame_kind   = out_data.frame_kind;
  assign frame.cmd_byte     = out_data.cmd_byte;
  assign frame.func_code    = out_data.func_code;
  assign frame.payload      = out_data.payload;
  assign frame.frame_length = out_data.frame_length;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for serial_frame_receiver: random byte streams with frames.
// Depends on sfr_pkg, sfr_if and the RTL under hdl/; checks every frame transfer.
module tb_top;
  import sfr_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sfr_byte_if  rx_ch ();
  sfr_frame_if frame_ch ();

  serial_frame_receiver dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .frame   (frame_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parser copy: configuration, state and the frames still owed by the block
  logic [7:0]  ans_code = 8'd2;
  logic [7:0]  rep_code = 8'd3;
  logic [7:0]  err_code = 8'd4;
  phase_t      ph = PH_HUNT_FIRST;
  logic [7:0]  body_count = '0;
  logic [7:0]  frame_len = '0;
  logic [7:0]  csum = '0;
  logic [7:0]  cmd_hold = '0;
  logic [7:0]  func_hold = '0;
  logic [31:0] pay_hold = '0;
  result_t     frames_due[$];

  logic [7:0]  bytes_to_send[$];
  int unsigned bytes_pushed = 0;
  bit          byte_taken = 1'b0;
  bit          failed = 1'b0;
  int unsigned gap_max = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  int unsigned stall_left = 0;

  function automatic kind_t kind_of(logic [7:0] c);
    if (c == ans_code) return KIND_ANSWER;
    if (c == rep_code) return KIND_REPORT;
    if (c == err_code) return KIND_ERROR;
    return KIND_OTHER;
  endfunction

  function automatic void close_frame(status_t st);
    result_t r;
    r.frame_status = st;
    r.frame_kind   = kind_of(cmd_hold);
    r.cmd_byte     = cmd_hold;
    r.func_code    = func_hold;
    r.payload      = pay_hold;
    r.frame_length = frame_len;
    frames_due.push_back(r);
    ph = PH_HUNT_FIRST;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [7:0] off;
    case (ph)
      PH_HUNT_FIRST: begin
        if (b == HEADER_BYTE) ph = PH_HUNT_SECOND;
      end
      PH_HUNT_SECOND: begin
        ph = (b == HEADER_BYTE) ? PH_LENGTH : PH_HUNT_FIRST;
      end
      PH_LENGTH: begin
        frame_len  = b;
        csum       = b;
        body_count = '0;
        cmd_hold   = '0;
        func_hold  = '0;
        pay_hold   = '0;
        if (b == 8'd0) close_frame(ST_SHORT_LEN);
        else ph = PH_BODY;
      end
      default: begin
        body_count = body_count + 8'd1;
        if (body_count >= frame_len) begin
          // short length wins over a bad checksum
          if (frame_len < MIN_LENGTH) close_frame(ST_SHORT_LEN);
          else if (b != csum) close_frame(ST_BAD_SUM);
          else close_frame(ST_GOOD);
        end else begin
          csum = csum + b;
          off = body_count + 8'd2;
          if (off == 8'd3) cmd_hold = b;
          else if (off == 8'd4) func_hold = b;
          else if (off >= 8'd5 && off <= 8'd8) pay_hold[8*(off-8'd5) +: 8] = b;
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h actual 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Monitor: check the frame transfer first, then predict from the byte transfer
  always @(posedge clk) begin : monitor
    result_t want;
    byte_taken <= rx_ch.valid && rx_ch.ready;
    if (!rst) begin
      if (frame_ch.valid && frame_ch.ready) begin
        if (frames_due.size() == 0) begin
          $error("frame transfer with none expected: cmd_byte 0x%0h frame_length %0d",
                 frame_ch.cmd_byte, frame_ch.frame_length);
          failed = 1'b1;
        end else begin
          want = frames_due.pop_front();
          check_field("frame_status", 32'(want.frame_status), 32'(frame_ch.frame_status));
          check_field("frame_kind", 32'(want.frame_kind), 32'(frame_ch.frame_kind));
          check_field("cmd_byte", 32'(want.cmd_byte), 32'(frame_ch.cmd_byte));
          check_field("func_code", 32'(want.func_code), 32'(frame_ch.func_code));
          check_field("payload", want.payload, frame_ch.payload);
          check_field("frame_length", 32'(want.frame_length), 32'(frame_ch.frame_length));
        end
      end
      if (rx_ch.valid && rx_ch.ready) parse_byte(rx_ch.rx_byte);
    end
  end

  // Byte driver: bursts of random length, random gaps between them
  always @(negedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (rx_ch.valid && !byte_taken) begin
      // hold until the transfer happens
    end else if (gap_left > 0) begin
      rx_ch.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (bytes_to_send.size() > 0) begin
      rx_ch.valid <= 1'b1;
      rx_ch.rx_byte <= bytes_to_send.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      rx_ch.valid <= 1'b0;
    end
  end

  // Frame receiver stalls
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: frame_ch.ready <= 1'b1;
      1: frame_ch.ready <= 1'($urandom_range(0, 1));
      2: frame_ch.ready <= (stall_tick % 7) >= 3;
      default: begin
        if (stall_left > 0) begin
          frame_ch.ready <= 1'b0;
          stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          frame_ch.ready <= 1'b0;
          stall_left <= $urandom_range(5, 30);
        end else begin
          frame_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  function automatic void send_byte(logic [7:0] b);
    bytes_to_send.push_back(b);
    bytes_pushed++;
  endfunction

  // fill < 0 draws random data bytes after cmd
  function automatic void add_frame(int unsigned len, logic [7:0] cmd, int fill, bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    send_byte(HEADER_BYTE);
    send_byte(HEADER_BYTE);
    send_byte(len[7:0]);
    sum = len[7:0];
    for (int k = 1; k < len; k++) begin
      if (k == 1) b = cmd;
      else if (fill < 0) b = 8'($urandom_range(0, 255));
      else b = fill[7:0];
      sum = sum + b;
      send_byte(b);
    end
    if (len > 0) send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endfunction

  function automatic void add_random_traffic(int unsigned n_bytes);
    int unsigned mark;
    int unsigned pick;
    logic [7:0]  cmd;
    mark = bytes_pushed;
    while (bytes_pushed - mark < n_bytes) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: cmd = ans_code;
        1: cmd = rep_code;
        2: cmd = err_code;
        default: cmd = 8'($urandom_range(0, 255));
      endcase
      if (pick < 4) begin
        add_frame($urandom_range(17, 64), cmd, -1, 1'($urandom_range(0, 1)));
      end else if (pick < 66) begin
        add_frame($urandom_range(7, 16), cmd, -1, 1'b0);
      end else if (pick < 78) begin
        add_frame($urandom_range(7, 24), cmd, -1, 1'b1);
      end else if (pick < 88) begin
        add_frame($urandom_range(0, 6), cmd, -1, 1'($urandom_range(0, 1)));
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
      end else if (pick < 97) begin
        send_byte(HEADER_BYTE);
        send_byte(8'($urandom_range(0, 254)));
      end else begin
        // truncated frame: the next header gets swallowed as body
        send_byte(HEADER_BYTE);
        send_byte(HEADER_BYTE);
        send_byte(8'($urandom_range(7, 12)));
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || rx_ch.valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_code(reg_index_t idx, logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ANSWER_CODE: ans_code = value;
      REG_REPORT_CODE: rep_code = value;
      default:         err_code = value;
    endcase
    // read back with psel held
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(value)) begin
      $error("prdata at 0x%0h expected 0x%0h actual 0x%0h", paddr, value, prdata);
      failed = 1'b1;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_codes(logic [7:0] a, logic [7:0] r, logic [7:0] e);
    wait_idle();
    write_code(REG_ANSWER_CODE, a);
    write_code(REG_REPORT_CODE, r);
    write_code(REG_ERROR_CODE, e);
  endtask

  initial begin
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = '0;
    frame_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: broken header, zero length, one-byte frame, extreme fields
    gap_max = 3;
    send_byte(HEADER_BYTE);
    send_byte(8'h00);
    add_frame(0, 8'h00, -1, 1'b0);
    add_frame(1, 8'h00, -1, 1'b0);
    add_frame(7, 8'd2, 8'hFF, 1'b0);
    add_frame(7, 8'd3, 8'h00, 1'b1);

    set_codes(8'h00, 8'hFF, 8'h80);
    stall_mode = 1;
    gap_max = 8;
    add_random_traffic(50);

    // all three codes equal: answer must win
    set_codes(8'h5A, 8'h5A, 8'h5A);
    stall_mode = 2;
    add_random_traffic(40);

    set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    stall_mode = 3;
    add_frame(255, rep_code, -1, 1'b0);
    add_random_traffic(40);

    set_codes(8'hFF, 8'h00, 8'hFF);
    stall_mode = 1;
    gap_max = 2;
    add_random_traffic(40);

    set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    stall_mode = 0;
    gap_max = 0;
    add_random_traffic(40);

    wait_idle();
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("serial_frame_receiver: match");
    end else begin
      $display("serial_frame_receiver: mismatch");
    end
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("serial_frame_receiver: mismatch");
    $finish;
  end

endmodule
